// ===== rtl/frp_pkg.sv =====
// ----------------------------------------------------------------------------
// frp_pkg: shared types and constants of the FASTA record parser
// Phase codes, queue command format, result codes and byte helpers.
// ----------------------------------------------------------------------------
package frp_pkg;

  // record length counter width and its saturation value
  localparam int LEN_W = 32;
  localparam int CMP_W = (LEN_W > 32) ? LEN_W : 32;
  localparam logic [LEN_W-1:0] LEN_MAX = {LEN_W{1'b1}};

  // command queue between front and back
  localparam int QDEPTH = 4;
  localparam int QPTR_W = $clog2(QDEPTH);
  localparam int QCNT_W = $clog2(QDEPTH + 1);

  // configuration register indexes
  localparam int CFG_IDX_W = 2;
  localparam logic [CFG_IDX_W-1:0] REG_ALLOW_OTHER = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_MIN_LENGTH  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_MERGE_MODE  = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_EMIT_BASES  = 2'd3;

  // result kinds
  localparam logic [1:0] KIND_BASE    = 2'd0;
  localparam logic [1:0] KIND_SUMMARY = 2'd1;
  localparam logic [1:0] KIND_INVALID = 2'd2;

  // record status codes
  localparam logic [1:0] ST_OK       = 2'd0;
  localparam logic [1:0] ST_EMPTY    = 2'd1;
  localparam logic [1:0] ST_SHORT    = 2'd2;
  localparam logic [1:0] ST_OVERFLOW = 2'd3;

  // base codes
  localparam logic [2:0] BASE_A = 3'd0;
  localparam logic [2:0] BASE_C = 3'd1;
  localparam logic [2:0] BASE_G = 3'd2;
  localparam logic [2:0] BASE_T = 3'd3;
  localparam logic [2:0] BASE_N = 3'd4;

  // special bytes
  localparam logic [7:0] CH_GT  = 8'h3E;
  localparam logic [7:0] CH_CR  = 8'h0D;
  localparam logic [7:0] CH_LF  = 8'h0A;
  localparam logic [7:0] CH_EOF = 8'hFF;

  typedef enum logic [1:0] {
    PH_FIRST  = 2'd0,
    PH_HEADER = 2'd1,
    PH_BODY   = 2'd2,
    PH_IGNORE = 2'd3
  } phase_t;

  // what the back end does with one queue entry
  typedef enum logic [1:0] {
    OP_BASE     = 2'd0,
    OP_SEP_BASE = 2'd1,
    OP_SUMMARY  = 2'd2,
    OP_INVALID  = 2'd3
  } op_t;

  typedef struct packed {
    op_t         op;
    logic [2:0]  code;
    logic [31:0] length;
    logic [1:0]  status;
    logic [15:0] idx;
    logic        last;
  } cmd_t;

  // classification of one body byte
  typedef struct packed {
    logic       keep;
    logic [2:0] code;
  } base_t;

  function automatic base_t base_of(input logic [7:0] b, input logic allow);
    logic [7:0] u;
    base_t      r;
    u      = (b >= 8'd97 && b <= 8'd122) ? (b - 8'd32) : b;
    r.keep = 1'b1;
    r.code = BASE_N;
    if (u < 8'd65 || u > 8'd90) begin
      r.keep = 1'b0;
    end else if (u == 8'h41) begin
      r.code = BASE_A;
    end else if (u == 8'h43) begin
      r.code = BASE_C;
    end else if (u == 8'h47) begin
      r.code = BASE_G;
    end else if (u == 8'h54) begin
      r.code = BASE_T;
    end else begin
      r.keep = allow;
    end
    return r;
  endfunction

  // reported length, capped at 32 bits
  function automatic logic [31:0] sat_len(input logic [LEN_W-1:0] n);
    logic [31:0] r;
    if (CMP_W'(n) > CMP_W'(32'hFFFF_FFFF)) begin
      r = 32'hFFFF_FFFF;
    end else begin
      r = 32'(n);
    end
    return r;
  endfunction

endpackage

// ===== rtl/frp_byte_if.sv =====
// ----------------------------------------------------------------------------
// frp_byte_if: input byte channel
// Valid/ready channel carrying one file byte and an end marker.
// ----------------------------------------------------------------------------
interface frp_byte_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       end_marker;

  modport source (output valid, data_byte, end_marker, input ready);
  modport sink   (input valid, data_byte, end_marker, output ready);
endinterface

// ===== rtl/frp_result_if.sv =====
// ----------------------------------------------------------------------------
// frp_result_if: result channel
// Valid/ready channel carrying one base, record summary or invalid result.
// ----------------------------------------------------------------------------
interface frp_result_if;
  logic        valid;
  logic        ready;
  logic [1:0]  kind;
  logic [2:0]  base_code;
  logic [31:0] record_length;
  logic [1:0]  record_status;
  logic [15:0] accepted_index;
  logic        last_of_file;

  modport source (output valid, kind, base_code, record_length, record_status,
                  accepted_index, last_of_file, input ready);
  modport sink   (input valid, kind, base_code, record_length, record_status,
                  accepted_index, last_of_file, output ready);
endinterface

// ===== rtl/frp_front.sv =====
// ----------------------------------------------------------------------------
// frp_front: byte classifier and record bookkeeping
// Tracks the parse phase and counters, and pushes commands into the queue.
// ----------------------------------------------------------------------------
module frp_front (
  input  logic                         clk,
  input  logic                         rst,
  frp_byte_if.sink                     byte_in,
  input  logic                         cfg_we,
  input  logic [frp_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [31:0]                  cfg_data,
  input  logic                         q_full,
  output logic                         push,
  output frp_pkg::cmd_t                push_cmd
);

  frp_pkg::phase_t          phase, phase_next;
  logic [frp_pkg::LEN_W-1:0] record_count, record_count_next;
  logic [15:0]              accepted_count, accepted_count_next;

  logic        allow_other_letters;
  logic [31:0] min_length;
  logic        merge_mode;
  logic        emit_bases;

  logic           accept;
  logic           eof;
  frp_pkg::base_t cls;
  logic [1:0]     sum_status;
  logic [15:0]    sum_acc;

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      allow_other_letters <= 1'b1;
      min_length          <= '0;
      merge_mode          <= 1'b0;
      emit_bases          <= 1'b1;
    end else if (cfg_we) begin
      case (cfg_index)
        frp_pkg::REG_ALLOW_OTHER: allow_other_letters <= cfg_data[0];
        frp_pkg::REG_MIN_LENGTH:  min_length          <= cfg_data;
        frp_pkg::REG_MERGE_MODE:  merge_mode          <= cfg_data[0];
        frp_pkg::REG_EMIT_BASES:  emit_bases          <= cfg_data[0];
        default: ;
      endcase
    end
  end

  assign byte_in.ready = !q_full;
  assign accept        = byte_in.valid && byte_in.ready;
  assign eof           = byte_in.end_marker || (byte_in.data_byte == frp_pkg::CH_EOF);
  assign cls           = frp_pkg::base_of(byte_in.data_byte, allow_other_letters);

  // status of the record that closes now
  always_comb begin
    sum_acc = accepted_count;
    if (record_count == '0) begin
      sum_status = frp_pkg::ST_EMPTY;
    end else if (min_length != 32'd0 &&
                 frp_pkg::CMP_W'(record_count) < frp_pkg::CMP_W'(min_length)) begin
      sum_status = frp_pkg::ST_SHORT;
    end else if (record_count == frp_pkg::LEN_MAX) begin
      sum_status = frp_pkg::ST_OVERFLOW;
    end else begin
      sum_status = frp_pkg::ST_OK;
      if (accepted_count != 16'hFFFF) begin
        sum_acc = accepted_count + 16'd1;
      end
    end
  end

  // phase and counter registers
  always_ff @(posedge clk) begin
    if (rst) begin
      phase          <= frp_pkg::PH_FIRST;
      record_count   <= '0;
      accepted_count <= '0;
    end else begin
      phase          <= phase_next;
      record_count   <= record_count_next;
      accepted_count <= accepted_count_next;
    end
  end

  // next phase and queue command
  always_comb begin
    phase_next          = phase;
    record_count_next   = record_count;
    accepted_count_next = accepted_count;
    push                = 1'b0;
    push_cmd            = '0;
    if (accept) begin
      case (phase)
        frp_pkg::PH_FIRST: begin
          if (eof) begin
            push        = 1'b1;
            push_cmd.op = frp_pkg::OP_INVALID;
            push_cmd.last = 1'b1;
            record_count_next   = '0;
            accepted_count_next = '0;
          end else if (byte_in.data_byte == frp_pkg::CH_GT) begin
            phase_next        = frp_pkg::PH_HEADER;
            record_count_next = '0;
          end else begin
            push          = 1'b1;
            push_cmd.op   = frp_pkg::OP_INVALID;
            push_cmd.last = 1'b1;
            phase_next    = frp_pkg::PH_IGNORE;
          end
        end
        frp_pkg::PH_HEADER, frp_pkg::PH_BODY: begin
          if (eof || (phase == frp_pkg::PH_BODY &&
                      byte_in.data_byte == frp_pkg::CH_GT)) begin
            push            = 1'b1;
            push_cmd.op     = frp_pkg::OP_SUMMARY;
            push_cmd.length = frp_pkg::sat_len(record_count);
            push_cmd.status = sum_status;
            push_cmd.idx    = sum_acc;
            push_cmd.last   = eof;
            record_count_next = '0;
            if (eof) begin
              phase_next          = frp_pkg::PH_FIRST;
              accepted_count_next = '0;
            end else begin
              phase_next          = frp_pkg::PH_HEADER;
              accepted_count_next = sum_acc;
            end
          end else if (phase == frp_pkg::PH_HEADER) begin
            if (byte_in.data_byte == frp_pkg::CH_CR ||
                byte_in.data_byte == frp_pkg::CH_LF) begin
              phase_next = frp_pkg::PH_BODY;
            end
          end else if (cls.keep && record_count != frp_pkg::LEN_MAX) begin
            record_count_next = record_count + 1'b1;
            if (emit_bases) begin
              push          = 1'b1;
              push_cmd.code = cls.code;
              if (merge_mode && accepted_count != 16'd0 && record_count == '0) begin
                push_cmd.op = frp_pkg::OP_SEP_BASE;
              end else begin
                push_cmd.op = frp_pkg::OP_BASE;
              end
            end
          end
        end
        frp_pkg::PH_IGNORE: begin
          if (eof) begin
            phase_next          = frp_pkg::PH_FIRST;
            record_count_next   = '0;
            accepted_count_next = '0;
          end
        end
        default: ;
      endcase
    end
  end

`ifndef SYNTH
  // any end of file leaves a clean state for the next file
  a_eof_clears: assert property (@(posedge clk) disable iff (rst)
    (accept && eof) |=> (phase == frp_pkg::PH_FIRST && record_count == '0 &&
                         accepted_count == 16'd0))
    else $error("end of file did not clear the parser state");

  // an accepted record always reports a nonzero index
  a_ok_index: assert property (@(posedge clk) disable iff (rst)
    (push && push_cmd.op == frp_pkg::OP_SUMMARY && push_cmd.status == frp_pkg::ST_OK)
      |-> (push_cmd.idx != 16'd0))
    else $error("accepted record with zero index");
`endif

endmodule

// ===== rtl/frp_queue.sv =====
// ----------------------------------------------------------------------------
// frp_queue: command queue
// Small FIFO of commands between the classifier and the result emitter.
// ----------------------------------------------------------------------------
module frp_queue (
  input  logic          clk,
  input  logic          rst,
  input  logic          push,
  input  frp_pkg::cmd_t push_cmd,
  output logic          full,
  output logic          head_valid,
  output frp_pkg::cmd_t head_cmd,
  input  logic          pop
);

  frp_pkg::cmd_t                 entries [frp_pkg::QDEPTH];
  logic [frp_pkg::QPTR_W-1:0]    wr_ptr, rd_ptr;
  logic [frp_pkg::QCNT_W-1:0]    count;

  assign full       = (count == frp_pkg::QCNT_W'(frp_pkg::QDEPTH));
  assign head_valid = (count != '0);
  assign head_cmd   = entries[rd_ptr];

  // storage
  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= push_cmd;
    end
  end

  // pointers and fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      case ({push, pop})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: ;
      endcase
    end
  end

`ifndef SYNTH
  // the fill count tracks the pointer distance
  a_count_ptrs: assert property (@(posedge clk) disable iff (rst)
    (count <= frp_pkg::QCNT_W'(frp_pkg::QDEPTH)) &&
    (frp_pkg::QPTR_W'(count) == frp_pkg::QPTR_W'(wr_ptr - rd_ptr)))
    else $error("queue fill count out of step with pointers");
`endif

endmodule

// ===== rtl/frp_back.sv =====
// ----------------------------------------------------------------------------
// frp_back: result emitter
// Turns queue commands into registered results, one per cycle unless stalled.
// ----------------------------------------------------------------------------
module frp_back (
  input  logic          clk,
  input  logic          rst,
  input  logic          head_valid,
  input  frp_pkg::cmd_t head_cmd,
  output logic          pop,
  frp_result_if.source  result_out
);

  logic out_valid;
  logic sep_done;
  logic load;
  logic emit_sep;

  // output register frees when empty or taken
  assign load     = head_valid && (!out_valid || result_out.ready);
  assign emit_sep = (head_cmd.op == frp_pkg::OP_SEP_BASE) && !sep_done;
  assign pop      = load && !emit_sep;

  assign result_out.valid = out_valid;

  // control
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
      sep_done  <= 1'b0;
    end else begin
      if (load) begin
        out_valid <= 1'b1;
      end else if (result_out.ready) begin
        out_valid <= 1'b0;
      end
      if (pop) begin
        sep_done <= 1'b0;
      end else if (load && emit_sep) begin
        sep_done <= 1'b1;
      end
    end
  end

  // payload
  always_ff @(posedge clk) begin
    if (load) begin
      result_out.base_code      <= 3'd0;
      result_out.record_length  <= '0;
      result_out.record_status  <= 2'd0;
      result_out.accepted_index <= '0;
      result_out.last_of_file   <= 1'b0;
      case (head_cmd.op)
        frp_pkg::OP_BASE: begin
          result_out.kind      <= frp_pkg::KIND_BASE;
          result_out.base_code <= head_cmd.code;
        end
        frp_pkg::OP_SEP_BASE: begin
          result_out.kind      <= frp_pkg::KIND_BASE;
          result_out.base_code <= emit_sep ? frp_pkg::BASE_N : head_cmd.code;
        end
        frp_pkg::OP_SUMMARY: begin
          result_out.kind           <= frp_pkg::KIND_SUMMARY;
          result_out.record_length  <= head_cmd.length;
          result_out.record_status  <= head_cmd.status;
          result_out.accepted_index <= head_cmd.idx;
          result_out.last_of_file   <= head_cmd.last;
        end
        default: begin
          result_out.kind         <= frp_pkg::KIND_INVALID;
          result_out.last_of_file <= head_cmd.last;
        end
      endcase
    end
  end

`ifndef SYNTH
  // a pending separator belongs to a separator command at the queue head
  a_sep_head: assert property (@(posedge clk) disable iff (rst)
    sep_done |-> (head_valid && head_cmd.op == frp_pkg::OP_SEP_BASE))
    else $error("separator flag without matching queue head");
`endif

endmodule

// ===== rtl/fasta_record_parser.sv =====
// ----------------------------------------------------------------------------
// fasta_record_parser: streaming FASTA byte parser
// Classifies file bytes and reports bases and per-record summaries.
// ----------------------------------------------------------------------------
// byte_in carries one file byte per request (end_marker or byte 255 ends the
// file); result_out carries base, record summary and invalid-file results.
// Registers are written through cfg_we/cfg_index/cfg_data, by the user only
// while idle, which the block does not enforce: 0 allow_other_letters,
// 1 min_length, 2 merge_mode, 3 emit_bases. A byte is taken every cycle
// while the 4-entry command queue has room; the classifier decides the
// record state in the cycle it takes the byte and queues at most one
// command. The emitter drains one result per cycle into an output register
// while result_out is ready. A merge separator adds an extra result, which
// the queue soaks up, so while result_out is ready the sustained rate
// stays at one byte per cycle. Reset clears the phase, counters and queue,
// and sets the registers to their defaults. When result_out stalls, the
// queue fills up to four commands and byte_in.ready drops; nothing is lost.
// ----------------------------------------------------------------------------
module fasta_record_parser (
  input  logic                          clk,
  input  logic                          rst,
  frp_byte_if.sink                      byte_in,
  frp_result_if.source                  result_out,
  input  logic                          cfg_we,
  input  logic [frp_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [31:0]                   cfg_data
);

  logic          q_full;
  logic          push;
  frp_pkg::cmd_t push_cmd;
  logic          head_valid;
  frp_pkg::cmd_t head_cmd;
  logic          pop;

  frp_front u_front (
    .clk       (clk),
    .rst       (rst),
    .byte_in   (byte_in),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .q_full    (q_full),
    .push      (push),
    .push_cmd  (push_cmd)
  );

  frp_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .push_cmd   (push_cmd),
    .full       (q_full),
    .head_valid (head_valid),
    .head_cmd   (head_cmd),
    .pop        (pop)
  );

  frp_back u_back (
    .clk        (clk),
    .rst        (rst),
    .head_valid (head_valid),
    .head_cmd   (head_cmd),
    .pop        (pop),
    .result_out (result_out)
  );

endmodule

// ===== tb/frp_checker.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// frp_checker: result predictor and scoreboard for the FASTA record parser
// Watches the byte, result and register ports, tracks the parser state in
// its own model, queues the results each byte request should cause, and
// compares every result request with the oldest queued one, field by field.
// ----------------------------------------------------------------------------
module frp_checker (
  input  logic                          clk,
  input  logic                          rst,
  frp_byte_if                           byte_ch,
  frp_result_if                         res_ch,
  input  logic                          cfg_we,
  input  logic [frp_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [31:0]                   cfg_data,
  output int unsigned                   error_count,
  output int unsigned                   open_count
);

  typedef struct packed {
    logic [1:0]  kind;
    logic [2:0]  base_code;
    logic [31:0] length;
    logic [1:0]  status;
    logic [15:0] acc_idx;
    logic        last;
  } result_t;

  // register copies
  logic        allow_n;
  logic [31:0] min_len;
  logic        merge_on;
  logic        emit_on;

  // parser state copy
  frp_pkg::phase_t           file_ph;
  logic [frp_pkg::LEN_W-1:0] base_count;
  logic [15:0]               accepted;

  result_t     expected_q[$];
  int unsigned errors = 0;

  // Kept-base lookup for one body byte; returns 0 when the byte is dropped.
  function automatic logic body_base(input logic [7:0] b, output logic [2:0] code);
    logic [7:0] up;
    up   = (b >= "a" && b <= "z") ? b - 8'd32 : b;
    code = frp_pkg::BASE_N;
    case (up)
      "A": code = frp_pkg::BASE_A;
      "C": code = frp_pkg::BASE_C;
      "G": code = frp_pkg::BASE_G;
      "T": code = frp_pkg::BASE_T;
      default: ;
    endcase
    if (up < "A" || up > "Z") return 1'b0;
    if (code != frp_pkg::BASE_N) return 1'b1;
    return allow_n;
  endfunction

  task automatic new_file();
    file_ph    = frp_pkg::PH_FIRST;
    base_count = '0;
    accepted   = '0;
  endtask

  task automatic push_base(input logic [2:0] code);
    result_t r;
    r           = '0;
    r.kind      = frp_pkg::KIND_BASE;
    r.base_code = code;
    expected_q.push_back(r);
  endtask

  task automatic push_invalid();
    result_t r;
    r      = '0;
    r.kind = frp_pkg::KIND_INVALID;
    r.last = 1'b1;
    expected_q.push_back(r);
  endtask

  // Close the current record: status priority is empty, short, overflow, ok
  task automatic close_record(input logic last);
    result_t r;
    r        = '0;
    r.kind   = frp_pkg::KIND_SUMMARY;
    r.length = (base_count > frp_pkg::LEN_W'(32'hFFFF_FFFF)) ? 32'hFFFF_FFFF
                                                             : 32'(base_count);
    r.last   = last;
    if (base_count == '0) begin
      r.status = frp_pkg::ST_EMPTY;
    end else if (min_len != 32'd0 && base_count < frp_pkg::LEN_W'(min_len)) begin
      r.status = frp_pkg::ST_SHORT;
    end else if (base_count == frp_pkg::LEN_MAX) begin
      r.status = frp_pkg::ST_OVERFLOW;
    end else begin
      r.status = frp_pkg::ST_OK;
      if (accepted != 16'hFFFF) accepted++;
    end
    r.acc_idx = accepted;
    expected_q.push_back(r);
    base_count = '0;
  endtask

  // Advance the model by one byte request
  task automatic predict(input logic [7:0] b, input logic eom);
    logic       eof;
    logic       keep;
    logic [2:0] code;
    eof = eom || (b == frp_pkg::CH_EOF);
    case (file_ph)
      frp_pkg::PH_FIRST: begin
        if (eof) begin
          push_invalid();
          new_file();
        end else if (b == frp_pkg::CH_GT) begin
          file_ph    = frp_pkg::PH_HEADER;
          base_count = '0;
        end else begin
          push_invalid();
          file_ph = frp_pkg::PH_IGNORE;
        end
      end
      frp_pkg::PH_HEADER: begin
        if (eof) begin
          close_record(1'b1);
          new_file();
        end else if (b == frp_pkg::CH_CR || b == frp_pkg::CH_LF) begin
          file_ph = frp_pkg::PH_BODY;
        end
      end
      frp_pkg::PH_BODY: begin
        if (eof) begin
          close_record(1'b1);
          new_file();
        end else if (b == frp_pkg::CH_GT) begin
          close_record(1'b0);
          file_ph = frp_pkg::PH_HEADER;
        end else begin
          keep = body_base(b, code);
          if (keep && base_count != frp_pkg::LEN_MAX) begin
            if (emit_on) begin
              // separator ahead of the first base after an accepted record
              if (merge_on && accepted != 16'd0 && base_count == '0) begin
                push_base(frp_pkg::BASE_N);
              end
              push_base(code);
            end
            base_count++;
          end
        end
      end
      default: begin
        if (eof) new_file();
      end
    endcase
  endtask

  function automatic int field_bad(input string name, input logic [31:0] want,
                                   input logic [31:0] got);
    if (got !== want) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      return 1;
    end
    return 0;
  endfunction

  task automatic check_result();
    result_t want;
    if (expected_q.size() == 0) begin
      $error("unexpected result: kind %0d base %0d length %0d status %0d",
             res_ch.kind, res_ch.base_code, res_ch.record_length, res_ch.record_status);
      errors++;
      return;
    end
    want = expected_q.pop_front();
    errors += field_bad("kind", 32'(want.kind), 32'(res_ch.kind));
    errors += field_bad("base_code", 32'(want.base_code), 32'(res_ch.base_code));
    errors += field_bad("record_length", want.length, res_ch.record_length);
    errors += field_bad("record_status", 32'(want.status), 32'(res_ch.record_status));
    errors += field_bad("accepted_index", 32'(want.acc_idx),
                        32'(res_ch.accepted_index));
    errors += field_bad("last_of_file", 32'(want.last), 32'(res_ch.last_of_file));
  endtask

  // Results are checked before the byte of the same edge is predicted, since
  // no byte can produce a result in the cycle it is taken.
  always @(posedge clk) begin
    if (rst) begin
      allow_n  = 1'b1;
      min_len  = 32'd0;
      merge_on = 1'b0;
      emit_on  = 1'b1;
      new_file();
      expected_q.delete();
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          frp_pkg::REG_ALLOW_OTHER: allow_n  = cfg_data[0];
          frp_pkg::REG_MIN_LENGTH:  min_len  = cfg_data;
          frp_pkg::REG_MERGE_MODE:  merge_on = cfg_data[0];
          frp_pkg::REG_EMIT_BASES:  emit_on  = cfg_data[0];
          default: ;
        endcase
      end
      if (res_ch.valid === 1'b1 && res_ch.ready === 1'b1) check_result();
      if (byte_ch.valid === 1'b1 && byte_ch.ready === 1'b1)
        predict(byte_ch.data_byte, byte_ch.end_marker);
    end
    error_count <= errors;
    open_count  <= expected_q.size();
  end

endmodule

// ===== tb/testbench.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench: top level for the FASTA record parser
// Drives directed byte sequences and then random FASTA files through several
// register settings, with random idling on both channels, a long stretch
// without idling and one long result hold-off; the checker judges results.
// ----------------------------------------------------------------------------
module testbench;

  localparam int unsigned RANDOM_ITEMS = 1150;
  localparam int          NUM_SETS     = 6;
  localparam int unsigned HOLD_CYCLES  = 300;
  localparam int unsigned DRAIN_CYCLES = 16;
  localparam int unsigned STUCK_LIMIT  = 5000;

  logic clk = 1'b0;
  logic rst;

  logic                          cfg_we;
  logic [frp_pkg::CFG_IDX_W-1:0] cfg_index;
  logic [31:0]                   cfg_data;

  int unsigned error_count;
  int unsigned open_count;
  int unsigned sent_items = 0;
  int unsigned stuck_cycles = 0;

  logic no_idle;
  logic hold_req;

  frp_byte_if   byte_ch ();
  frp_result_if res_ch ();

  always #4 clk = ~clk;

  fasta_record_parser u_dut (
    .clk        (clk),
    .rst        (rst),
    .byte_in    (byte_ch),
    .result_out (res_ch),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data)
  );

  frp_checker u_checker (
    .clk         (clk),
    .rst         (rst),
    .byte_ch     (byte_ch),
    .res_ch      (res_ch),
    .cfg_we      (cfg_we),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data),
    .error_count (error_count),
    .open_count  (open_count)
  );

  // Offer one byte request and wait for it to be taken
  task automatic push_byte(input logic [7:0] b, input logic eom);
    while (!no_idle && $urandom_range(99) < 14) begin
      byte_ch.valid <= 1'b0;
      @(posedge clk);
    end
    byte_ch.valid      <= 1'b1;
    byte_ch.data_byte  <= b;
    byte_ch.end_marker <= eom;
    do @(posedge clk); while (byte_ch.ready !== 1'b1);
    sent_items++;
  endtask

  // End of file: either byte 255 or the marker with a random byte
  task automatic send_eof();
    if ($urandom_range(1)) push_byte(frp_pkg::CH_EOF, 1'b0);
    else push_byte(8'($urandom_range(255)), 1'b1);
  endtask

  function automatic logic [7:0] header_byte();
    logic [7:0] b;
    do b = 8'($urandom_range(254)); while (b == frp_pkg::CH_CR || b == frp_pkg::CH_LF);
    return b;
  endfunction

  // Body bytes: mostly bases, some other letters, line breaks and noise
  function automatic logic [7:0] body_byte();
    int unsigned r;
    logic [7:0]  b;
    r = $urandom_range(99);
    if (r < 55) begin
      case ($urandom_range(3))
        0: b = "A";
        1: b = "C";
        2: b = "G";
        default: b = "T";
      endcase
      if ($urandom_range(1)) b = b | 8'h20;
    end else if (r < 68) begin
      b = 8'd65 + 8'($urandom_range(25));
      if ($urandom_range(1)) b = b | 8'h20;
    end else if (r < 78) begin
      b = $urandom_range(1) ? frp_pkg::CH_LF : frp_pkg::CH_CR;
    end else begin
      do b = 8'($urandom_range(254)); while (b == frp_pkg::CH_GT);
    end
    return b;
  endfunction

  // One random file: mostly well formed, sometimes a bad first byte or no records
  task automatic send_file();
    int unsigned nrec;
    int unsigned blen;
    logic [7:0]  b;
    if ($urandom_range(99) < 8) begin
      if ($urandom_range(1)) begin
        do b = 8'($urandom_range(254)); while (b == frp_pkg::CH_GT);
        push_byte(b, 1'b0);
        repeat ($urandom_range(5)) push_byte(8'($urandom_range(254)), 1'b0);
      end
      send_eof();
      return;
    end
    nrec = $urandom_range(1, 4);
    for (int i = 0; i < nrec; i++) begin
      push_byte(frp_pkg::CH_GT, 1'b0);
      repeat ($urandom_range(6)) push_byte(header_byte(), 1'b0);
      // file cut off inside a header
      if ($urandom_range(99) < 4) begin
        send_eof();
        return;
      end
      push_byte($urandom_range(1) ? frp_pkg::CH_LF : frp_pkg::CH_CR, 1'b0);
      blen = ($urandom_range(99) < 5) ? $urandom_range(20, 60) : $urandom_range(12);
      repeat (blen) push_byte(body_byte(), 1'b0);
    end
    send_eof();
  endtask

  task automatic write_reg(input logic [frp_pkg::CFG_IDX_W-1:0] idx,
                           input logic [31:0] value);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value;
    @(posedge clk);
  endtask

  task automatic program_regs(input logic allow, input logic [31:0] min_length,
                              input logic merge, input logic emit);
    write_reg(frp_pkg::REG_ALLOW_OTHER, {31'd0, allow});
    write_reg(frp_pkg::REG_MIN_LENGTH, min_length);
    write_reg(frp_pkg::REG_MERGE_MODE, {31'd0, merge});
    write_reg(frp_pkg::REG_EMIT_BASES, {31'd0, emit});
    cfg_we <= 1'b0;
  endtask

  // Wait until every expected result is in, then let the pipe settle
  task automatic drain();
    @(posedge clk);
    while (open_count != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  // Byte source and register writes
  initial begin : stimulus
    string body;
    rst                <= 1'b1;
    byte_ch.valid      <= 1'b0;
    byte_ch.data_byte  <= 8'd0;
    byte_ch.end_marker <= 1'b0;
    cfg_we             <= 1'b0;
    cfg_index          <= frp_pkg::REG_ALLOW_OTHER;
    cfg_data           <= 32'd0;
    no_idle            <= 1'b0;
    hold_req           <= 1'b0;
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed part under reset defaults
    push_byte(8'h00, 1'b1);          // end of file before any byte
    push_byte("A", 1'b0);            // bad first byte, rest ignored
    push_byte(frp_pkg::CH_GT, 1'b0);
    push_byte(8'h80, 1'b0);
    push_byte(frp_pkg::CH_EOF, 1'b0); // end after bad first byte: silent
    push_byte(frp_pkg::CH_GT, 1'b0);
    push_byte(8'h41, 1'b1);          // end inside a header: empty record
    push_byte(frp_pkg::CH_GT, 1'b0);
    push_byte(frp_pkg::CH_GT, 1'b0); // '>' inside a header is skipped
    push_byte(frp_pkg::CH_CR, 1'b0);
    body = "aCgTnZ@[{z";             // letter edges and neighbors
    for (int i = 0; i < body.len(); i++) push_byte(body[i], 1'b0);
    push_byte(8'h60, 1'b0);          // just below 'a'
    push_byte(8'h7F, 1'b0);
    push_byte(frp_pkg::CH_GT, 1'b0);
    push_byte(frp_pkg::CH_LF, 1'b0);
    push_byte(frp_pkg::CH_GT, 1'b0); // empty record in the body
    push_byte(frp_pkg::CH_LF, 1'b0);
    push_byte("t", 1'b0);
    push_byte(frp_pkg::CH_EOF, 1'b0);
    byte_ch.valid <= 1'b0;

    // random files under several register settings
    for (int p = 0; p < NUM_SETS; p++) begin
      drain();
      case (p)
        0: program_regs(1'b0, 32'd0, 1'b1, 1'b1);
        1: program_regs(1'b1, 32'hFFFF_FFFF, 1'b1, 1'b1);
        2: program_regs(1'b1, 32'd1, 1'b1, 1'b1);
        3: program_regs(1'b0, 32'd6, 1'b0, 1'b0);
        4: program_regs(1'b1, 32'd3, 1'b1, 1'b1);
        default: program_regs(1'b1, 32'd0, 1'b0, 1'b1);
      endcase
      no_idle <= (p == 0);
      if (p == 2) hold_req <= 1'b1;
      while (sent_items < (p + 1) * (RANDOM_ITEMS / NUM_SETS) + 30) send_file();
      byte_ch.valid <= 1'b0;
    end

    drain();
    if (error_count == 0 && open_count == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

  // Result sink: random stalls, one long hold-off
  initial begin : result_sink
    logic held;
    held = 1'b0;
    res_ch.ready <= 1'b0;
    @(posedge clk);
    forever begin
      if (hold_req && !held) begin
        held = 1'b1;
        res_ch.ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
      end else begin
        res_ch.ready <= no_idle || ($urandom_range(99) >= 14);
        @(posedge clk);
      end
    end
  end

  // Watchdog: too long without any request taken on either channel
  always @(posedge clk) begin
    if (!rst) begin
      if ((byte_ch.valid && byte_ch.ready) || (res_ch.valid && res_ch.ready)) begin
        stuck_cycles <= 0;
      end else if (stuck_cycles >= STUCK_LIMIT) begin
        $display("FAIL");
        $finish;
      end else begin
        stuck_cycles <= stuck_cycles + 1;
      end
    end
  end

endmodule
